### hdl/dotp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dotp_pkg;

  localparam int unsigned PosWidth = 9;
  localparam logic [PosWidth-1:0] OPTION_AREA_BYTES = PosWidth'(308);

  localparam logic [7:0] TAG_PAD     = 8'd0;
  localparam logic [7:0] TAG_MASK    = 8'd1;
  localparam logic [7:0] TAG_ROUTER  = 8'd3;
  localparam logic [7:0] TAG_DNS     = 8'd6;
  localparam logic [7:0] TAG_MSGTYPE = 8'd53;
  localparam logic [7:0] TAG_SERVER  = 8'd54;
  localparam logic [7:0] TAG_END     = 8'd255;

  typedef struct packed {
    logic [7:0] option_byte;
    logic       first_byte;
    logic       clear_values;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  message_type;
    logic [31:0] subnet_mask;
    logic [31:0] router_addr;
    logic [31:0] dns_addr;
    logic [31:0] server_ident;
    logic        server_ident_found;
    logic        walk_done;
    logic        overrun;
  } out_item_t;

  // input register contents handed to the walker
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

endpackage

`default_nettype wire

### hdl/dotp_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module dotp_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire dotp_pkg::in_item_t in_item_i,
  input  wire logic              advance_i,
  output dotp_pkg::stage_t       stage_o
);

  logic              valid_q, valid_d;
  dotp_pkg::in_item_t item_q;
  logic              load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

`default_nettype wire

### hdl/dotp_walker.sv
`timescale 1ns / 1ps
`default_nettype none

module dotp_walker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dotp_pkg::stage_t   stage_i,
  output logic                    advance_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output dotp_pkg::out_item_t     out_item_o
);

  typedef enum logic [1:0] {
    PH_TAG,
    PH_LEN,
    PH_VAL,
    PH_DONE
  } phase_e;

  phase_e                            phase_q, phase_d;
  logic [7:0]                        tag_q, tag_d;
  logic [7:0]                        len_q, len_d;
  logic [7:0]                        idx_q, idx_d;
  logic [31:0]                       shift_q, shift_d;
  logic [dotp_pkg::PosWidth-1:0]     pos_q, pos_d;
  logic [7:0]                        type_q, type_d;
  logic                              type_seen_q, type_seen_d;
  logic [31:0]                       mask_q, mask_d;
  logic [31:0]                       router_q, router_d;
  logic [31:0]                       dns_q, dns_d;
  logic [31:0]                       server_q, server_d;
  logic                              server_seen_q, server_seen_d;
  logic                              done_q, done_d;
  logic                              ovr_q, ovr_d;
  logic                              out_valid_q, out_valid_d;

  logic                              first;
  logic                              clr;
  logic [7:0]                        b;
  logic                              count;

  assign advance_o   = stage_i.valid && (!out_valid_q || out_ready_i);
  assign out_valid_d = advance_o || (out_valid_q && !out_ready_i);

  assign first = stage_i.item.first_byte;
  assign clr   = first && stage_i.item.clear_values;
  assign b     = stage_i.item.option_byte;

  always_comb begin
    phase_d       = first ? PH_TAG : phase_q;
    pos_d         = first ? '0 : pos_q;
    done_d        = first ? 1'b0 : done_q;
    ovr_d         = first ? 1'b0 : ovr_q;
    tag_d         = tag_q;
    len_d         = len_q;
    idx_d         = idx_q;
    shift_d       = shift_q;
    type_d        = clr ? 8'd0 : type_q;
    type_seen_d   = clr ? 1'b0 : type_seen_q;
    mask_d        = clr ? 32'd0 : mask_q;
    router_d      = clr ? 32'd0 : router_q;
    dns_d         = clr ? 32'd0 : dns_q;
    server_d      = clr ? 32'd0 : server_q;
    server_seen_d = clr ? 1'b0 : server_seen_q;
    count         = 1'b1;

    unique case (phase_d)
      PH_TAG: begin
        if (b == dotp_pkg::TAG_END) begin
          phase_d = PH_DONE;
          done_d  = 1'b1;
          count   = 1'b0;
        end else if (b != dotp_pkg::TAG_PAD) begin
          tag_d   = b;
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        len_d   = b;
        idx_d   = 8'd0;
        shift_d = 32'd0;
        phase_d = (b == 8'd0) ? PH_TAG : PH_VAL;
      end
      PH_VAL: begin
        if (idx_q < 8'd4) begin
          shift_d = {shift_q[23:0], b};
        end
        idx_d = idx_q + 8'd1;
        if (idx_d == len_q) begin
          phase_d = PH_TAG;
          priority if (tag_q == dotp_pkg::TAG_MSGTYPE && len_q == 8'd1 && !type_seen_d) begin
            type_d      = shift_d[7:0];
            type_seen_d = 1'b1;
          end else if (tag_q == dotp_pkg::TAG_MASK && len_q == 8'd4) begin
            mask_d = shift_d;
          end else if (tag_q == dotp_pkg::TAG_ROUTER && len_q >= 8'd4) begin
            router_d = shift_d;
          end else if (tag_q == dotp_pkg::TAG_DNS && len_q >= 8'd4) begin
            dns_d = shift_d;
          end else if (tag_q == dotp_pkg::TAG_SERVER && len_q == 8'd4 && !server_seen_d) begin
            server_d      = shift_d;
            server_seen_d = 1'b1;
          end else begin
          end
        end
      end
      PH_DONE: begin
        count = 1'b0;
      end
      default: begin
        count = 1'b0;
      end
    endcase

    if (count) begin
      pos_d = pos_d + 1'b1;
      if (pos_d >= dotp_pkg::OPTION_AREA_BYTES) begin
        // limit cuts the walk; an open entry is an overrun
        if (phase_d != PH_TAG) begin
          ovr_d = 1'b1;
        end
        phase_d = PH_DONE;
        done_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_TAG;
      tag_q         <= 8'd0;
      len_q         <= 8'd0;
      idx_q         <= 8'd0;
      shift_q       <= 32'd0;
      pos_q         <= '0;
      type_q        <= 8'd0;
      type_seen_q   <= 1'b0;
      mask_q        <= 32'd0;
      router_q      <= 32'd0;
      dns_q         <= 32'd0;
      server_q      <= 32'd0;
      server_seen_q <= 1'b0;
      done_q        <= 1'b0;
      ovr_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance_o) begin
        phase_q       <= phase_d;
        tag_q         <= tag_d;
        len_q         <= len_d;
        idx_q         <= idx_d;
        shift_q       <= shift_d;
        pos_q         <= pos_d;
        type_q        <= type_d;
        type_seen_q   <= type_seen_d;
        mask_q        <= mask_d;
        router_q      <= router_d;
        dns_q         <= dns_d;
        server_q      <= server_d;
        server_seen_q <= server_seen_d;
        done_q        <= done_d;
        ovr_q         <= ovr_d;
      end
    end
  end

  // held values change only when an item advances, so they are the result
  assign out_valid_o                   = out_valid_q;
  assign out_item_o.message_type       = type_q;
  assign out_item_o.subnet_mask        = mask_q;
  assign out_item_o.router_addr        = router_q;
  assign out_item_o.dns_addr           = dns_q;
  assign out_item_o.server_ident       = server_q;
  assign out_item_o.server_ident_found = server_seen_q;
  assign out_item_o.walk_done          = done_q;
  assign out_item_o.overrun            = ovr_q;

endmodule

`default_nettype wire

### hdl/dhcp_option_tlv_parser.sv
// Result path: an accepted item is captured in the input register, then moves into
// the walker registers, whose held values form the result.
// Throughput: one item per cycle unless the result side stalls; the walker updates
// its phase and held values in a single pass as the item leaves the input register.
// Reset (rst_ni low, asynchronous): walk restarts at byte 0 expecting a tag,
// all held values and flags read zero, both channels empty.
`timescale 1ns / 1ps
`default_nettype none

module dhcp_option_tlv_parser (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire dotp_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output dotp_pkg::out_item_t      out_item_o
);

  dotp_pkg::stage_t stage;
  logic             advance;

  dotp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .advance_i  (advance),
    .stage_o    (stage)
  );

  dotp_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

### hdl/dotp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dotp_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire dotp_pkg::in_item_t  in_item_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire dotp_pkg::out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("result item changed while stalled");

  a_ovr_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.overrun |-> out_item_o.walk_done)
    else $error("overrun without walk done");

  a_server_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.server_ident_found |-> out_item_o.server_ident == 32'd0)
    else $error("server ident held without found flag");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind dhcp_option_tlv_parser dotp_checker u_dotp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

### sim/dhcp_option_walk_checker.sv
`timescale 1ns / 1ps

module dhcp_option_walk_checker
  import dotp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_item_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);

  typedef enum logic [1:0] {WALK_TAG, WALK_LEN, WALK_VAL, WALK_DONE} walk_phase_e;

  walk_phase_e phase;
  logic [7:0]  cur_tag;
  logic [7:0]  cur_len;
  logic [7:0]  val_idx;
  logic [31:0] val_acc;
  logic [8:0]  byte_pos;
  logic        type_seen;
  out_item_t   status;

  out_item_t   expected_status_q[$];
  int unsigned mismatches;

  task restart_walk();
    phase           = WALK_TAG;
    cur_tag         = '0;
    cur_len         = '0;
    val_idx         = '0;
    val_acc         = '0;
    byte_pos        = '0;
    status.walk_done = 1'b0;
    status.overrun  = 1'b0;
  endtask

  task clear_held();
    status.message_type       = '0;
    status.subnet_mask        = '0;
    status.router_addr        = '0;
    status.dns_addr           = '0;
    status.server_ident       = '0;
    status.server_ident_found = 1'b0;
    type_seen                 = 1'b0;
  endtask

  // advance the walk by one options byte; status then holds the expected outputs
  task walk_option_byte(input in_item_t it);
    logic [7:0] b;
    logic       hit_end;
    b       = it.option_byte;
    hit_end = 1'b0;
    if (it.first_byte) begin
      restart_walk();
      if (it.clear_values) clear_held();
    end
    if (phase != WALK_DONE) begin
      case (phase)
        WALK_TAG: begin
          if (b == TAG_END) begin
            phase            = WALK_DONE;
            status.walk_done = 1'b1;
            hit_end          = 1'b1;
          end else if (b != TAG_PAD) begin
            cur_tag = b;
            phase   = WALK_LEN;
          end
        end
        WALK_LEN: begin
          cur_len = b;
          val_idx = '0;
          val_acc = '0;
          phase   = (b == 8'd0) ? WALK_TAG : WALK_VAL;
        end
        default: begin
          if (val_idx < 8'd4) val_acc = {val_acc[23:0], b};
          val_idx = val_idx + 8'd1;
          if (val_idx == cur_len) begin
            if (cur_tag == TAG_MSGTYPE && cur_len == 8'd1 && !type_seen) begin
              status.message_type = val_acc[7:0];
              type_seen           = 1'b1;
            end else if (cur_tag == TAG_MASK && cur_len == 8'd4) begin
              status.subnet_mask = val_acc;
            end else if (cur_tag == TAG_ROUTER && cur_len >= 8'd4) begin
              status.router_addr = val_acc;
            end else if (cur_tag == TAG_DNS && cur_len >= 8'd4) begin
              status.dns_addr = val_acc;
            end else if (cur_tag == TAG_SERVER && cur_len == 8'd4 &&
                         !status.server_ident_found) begin
              status.server_ident       = val_acc;
              status.server_ident_found = 1'b1;
            end
            phase = WALK_TAG;
          end
        end
      endcase
      if (!hit_end) begin
        byte_pos = byte_pos + 9'd1;
        if (byte_pos >= OPTION_AREA_BYTES) begin
          // limit hit anywhere but between entries cuts one short
          if (phase != WALK_TAG) status.overrun = 1'b1;
          phase            = WALK_DONE;
          status.walk_done = 1'b1;
        end
      end
    end
  endtask

  function void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // inputs only change at the rising edge, so the falling edge sees what the
  // next rising edge will see
  always @(negedge clk_i) begin
    out_item_t want;
    if (!rst_ni) begin
      restart_walk();
      clear_held();
      expected_status_q.delete();
    end else begin
      if (in_valid_i === 1'b1 && in_ready_i === 1'b1) begin
        walk_option_byte(in_item_i);
        expected_status_q.push_back(status);
      end
      if (out_valid_i === 1'b1 && out_ready_i === 1'b1) begin
        if (expected_status_q.size() == 0) begin
          $error("result item arrived with no expected status pending");
          mismatches++;
        end else begin
          want = expected_status_q.pop_front();
          check_field("message_type", 32'(want.message_type), 32'(out_item_i.message_type));
          check_field("subnet_mask", want.subnet_mask, out_item_i.subnet_mask);
          check_field("router_addr", want.router_addr, out_item_i.router_addr);
          check_field("dns_addr", want.dns_addr, out_item_i.dns_addr);
          check_field("server_ident", want.server_ident, out_item_i.server_ident);
          check_field("server_ident_found", 32'(want.server_ident_found),
                      32'(out_item_i.server_ident_found));
          check_field("walk_done", 32'(want.walk_done), 32'(out_item_i.walk_done));
          check_field("overrun", 32'(want.overrun), 32'(out_item_i.overrun));
        end
      end
    end
    mismatch_count_o = mismatches;
    pending_o        = expected_status_q.size();
  end

endmodule

### sim/tb_dhcp_option_tlv_parser.sv
`timescale 1ns / 1ps

module tb_dhcp_option_tlv_parser;
  import dotp_pkg::*;

  // directed walk, started without first_byte right after reset
  localparam logic [159:0] OpeningWalk = {
    TAG_MSGTYPE, 8'd1, 8'h05,
    TAG_PAD,
    TAG_MASK, 8'd4, 8'hFF, 8'hFF, 8'hFF, 8'h00,
    TAG_SERVER, 8'd4, 8'h80, 8'h00, 8'h00, 8'h01,
    TAG_DNS, 8'd0,
    TAG_END,
    8'h12
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  in_item_t    in_item = '0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  out_item_t   out_item;
  int unsigned mismatch_count;
  int unsigned pending_count;

  logic        start_flag = 1'b0;
  logic        clear_flag = 1'b0;
  logic        quiet_walk = 1'b0;
  int unsigned sent_items = 0;

  logic        stall_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;

  always #5 clk_i = ~clk_i;

  dhcp_option_tlv_parser DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  dhcp_option_walk_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_item_i        (in_item),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_item_i       (out_item),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count)
  );

  // result side: bursts of stalls, with quiet stretches where it never stalls
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 300 == 299) stall_on <= ($urandom_range(0, 2) != 0);
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (stall_on && $urandom_range(0, 3) == 0) begin
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(6, 25)
                                                  : $urandom_range(1, 3);
      end
    end
  end

  task send_option_byte(input logic [7:0] b);
    int unsigned gap;
    logic        accepted;
    in_item_t    nxt;
    gap = 0;
    if (!quiet_walk) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: gap = 0;
        6, 7, 8:          gap = $urandom_range(1, 3);
        default:          gap = $urandom_range(8, 30);
      endcase
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    nxt.option_byte  = b;
    nxt.first_byte   = start_flag;
    nxt.clear_values = clear_flag;
    in_valid   <= 1'b1;
    in_item    <= nxt;
    start_flag = 1'b0;
    clear_flag = 1'b0;
    accepted   = 1'b0;
    while (!accepted) begin
      @(negedge clk_i);
      accepted = (in_ready === 1'b1);
      @(posedge clk_i);
    end
    sent_items++;
  endtask

  task send_entry(input logic [7:0] tag, input logic [7:0] len);
    send_option_byte(tag);
    send_option_byte(len);
    repeat (len) send_option_byte(8'($urandom_range(0, 255)));
  endtask

  task begin_walk(input logic clr);
    start_flag = 1'b1;
    clear_flag = clr;
    quiet_walk = ($urandom_range(0, 4) == 0);
  endtask

  // the last item was just accepted, so stop offering it while draining
  task wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
  endtask

  function logic [7:0] pick_tag();
    case ($urandom_range(0, 9))
      0:       return TAG_MASK;
      1:       return TAG_ROUTER;
      2:       return TAG_DNS;
      3:       return TAG_MSGTYPE;
      4:       return TAG_SERVER;
      default: return 8'($urandom_range(1, 254));
    endcase
  endfunction

  initial begin
    int unsigned kind;
    int unsigned filler;
    int unsigned room;
    int unsigned mode;
    logic [7:0]  tag;
    logic [7:0]  len;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 20; i++) send_option_byte(OpeningWalk[159 - 8*i -: 8]);
    // clear request without a restart is dropped, walk is still over
    clear_flag = 1'b1;
    send_option_byte(8'h35);
    // second walk keeps the first message type
    begin_walk(1'b0);
    send_option_byte(TAG_MSGTYPE);
    send_option_byte(8'd1);
    send_option_byte(8'h09);
    send_option_byte(TAG_END);
    wait_for_drain();

    while (sent_items < 90) begin
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        repeat ($urandom_range(1, 6)) begin
          start_flag = ($urandom_range(0, 3) == 0);
          clear_flag = $urandom_range(0, 1);
          send_option_byte(8'($urandom_range(0, 255)));
        end
      end else begin
        begin_walk($urandom_range(0, 3) == 0);
        repeat ($urandom_range(1, 5)) begin
          if ($urandom_range(0, 3) == 0) send_option_byte(TAG_PAD);
          tag = pick_tag();
          case (tag)
            TAG_MSGTYPE:
              len = ($urandom_range(0, 9) < 8) ? 8'd1 : 8'($urandom_range(0, 3));
            TAG_MASK, TAG_SERVER:
              len = ($urandom_range(0, 9) < 8) ? 8'd4 : 8'($urandom_range(0, 8));
            TAG_ROUTER, TAG_DNS:
              len = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(4, 10))
                                               : 8'($urandom_range(0, 3));
            default:
              len = 8'($urandom_range(0, 6));
          endcase
          send_entry(tag, len);
        end
        if (kind == 8) begin
          // entry broken off by the next restart
          send_option_byte(pick_tag());
          send_option_byte(8'd4);
          send_option_byte(8'($urandom_range(0, 255)));
        end else begin
          send_option_byte(TAG_END);
          repeat ($urandom_range(0, 2)) send_option_byte(8'($urandom_range(0, 255)));
        end
      end
    end

    // one walk that runs into the byte limit: exactly at an entry boundary,
    // right after a tag byte, or in the middle of a value
    mode = $urandom_range(0, 2);
    begin_walk(1'b0);
    filler = $urandom_range(200, 255);
    send_entry(pick_tag(), 8'(filler));
    room = OPTION_AREA_BYTES - (filler + 2);
    case (mode)
      0: send_entry(TAG_ROUTER, 8'(room - 2));
      1: begin
        send_entry(pick_tag(), 8'(room - 3));
        send_option_byte(TAG_SERVER);
      end
      default: send_entry(TAG_SERVER, 8'(room - 2 + $urandom_range(1, 20)));
    endcase

    wait_for_drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("dhcp_option_tlv_parser verification clean");
    end else begin
      $display("dhcp_option_tlv_parser verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("dhcp_option_tlv_parser verification failed");
    $finish;
  end

endmodule

### filelist.f
hdl/dotp_pkg.sv
hdl/dotp_in_stage.sv
hdl/dotp_walker.sv
hdl/dhcp_option_tlv_parser.sv
hdl/dotp_checker.sv
sim/dhcp_option_walk_checker.sv
sim/tb_dhcp_option_tlv_parser.sv
